@@ design/rfpc_pkg.sv @@
// Shared types and constants for the rectangle frame position classifier.
// No dependencies; every other design file depends on this package.
`timescale 1ns / 1ps

package rfpc_pkg;

	// Width of the configuration register index.
	localparam int CFG_IDX_W = 4;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT   = 4'd0,
		REG_TOP    = 4'd1,
		REG_WIDTH  = 4'd2,
		REG_HEIGHT = 4'd3
	} cfg_reg_t;

	// Compass direction codes of the result.
	typedef enum logic [3:0] {
		DIR_NONE = 4'd0,
		DIR_N    = 4'd1,
		DIR_NE   = 4'd2,
		DIR_E    = 4'd3,
		DIR_SE   = 4'd4,
		DIR_S    = 4'd5,
		DIR_SW   = 4'd6,
		DIR_W    = 4'd7,
		DIR_NW   = 4'd8
	} dir_t;

	// Position flags handed from the compare stage to the resolve stage.
	typedef struct packed {
		logic in_rect;
		logic frame;
		logic north;
		logic east;
		logic south;
		logic west;
	} pos_flags_t;

endpackage

@@ design/rfpc_channels.sv @@
// Channel interfaces of the classifier: position input, result output and
// configuration writes. Depends on rfpc_pkg for the register index width.
`timescale 1ns / 1ps

interface rfpc_pos_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;

	modport source (output valid, output pos_x, output pos_y, input ready);
	modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface rfpc_res_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic                         inside_res;
	logic                         on_frame;
	logic [3:0]                   direction;
	logic signed [COORD_BITS+1:0] frame_index;

	modport source (output valid, output inside_res, output on_frame, output direction,
		output frame_index, input ready);
	modport sink   (input valid, input inside_res, input on_frame, input direction,
		input frame_index, output ready);
endinterface

interface rfpc_cfg_if #(
	parameter int COORD_BITS = 16
);
	logic                           valid;
	logic                           ready;
	logic [rfpc_pkg::CFG_IDX_W-1:0] index;
	logic [COORD_BITS-1:0]          data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/rfpc_cfg_regs.sv @@
// Configuration register file of the classifier: rectangle corner and size.
// Depends on rfpc_pkg and the rfpc_cfg_if interface.
`timescale 1ns / 1ps

module rfpc_cfg_regs #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	rfpc_cfg_if.sink                     cfg,
	output logic signed [COORD_BITS-1:0] rect_left,
	output logic signed [COORD_BITS-1:0] rect_top,
	output logic [COORD_BITS-2:0]        rect_width,
	output logic [COORD_BITS-2:0]        rect_height
);
	import rfpc_pkg::*;

	logic signed [COORD_BITS-1:0] left_q;
	logic signed [COORD_BITS-1:0] top_q;
	logic [COORD_BITS-2:0]        width_q;
	logic [COORD_BITS-2:0]        height_q;

	// Writes are always taken; an unknown index is dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LEFT:   left_q   <= cfg.data;
				REG_TOP:    top_q    <= cfg.data;
				REG_WIDTH:  width_q  <= cfg.data[COORD_BITS-2:0];
				REG_HEIGHT: height_q <= cfg.data[COORD_BITS-2:0];
				default: ;
			endcase
		end
	end

	assign rect_left   = left_q;
	assign rect_top    = top_q;
	assign rect_width  = width_q;
	assign rect_height = height_q;
endmodule

@@ design/rfpc_compare.sv @@
// First pipeline stage: offsets of the position from the top-left corner and
// the inside and edge flags. Depends on rfpc_pkg.
`timescale 1ns / 1ps

module rfpc_compare #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         load,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] rect_left,
	input  logic signed [COORD_BITS-1:0] rect_top,
	input  logic [COORD_BITS-2:0]        rect_width,
	input  logic [COORD_BITS-2:0]        rect_height,
	output logic [COORD_BITS-2:0]        dx_s1,
	output logic [COORD_BITS-2:0]        dy_s1,
	output rfpc_pkg::pos_flags_t         flags_s1
);
	import rfpc_pkg::*;

	localparam int DW = COORD_BITS + 1;

	logic [DW-1:0] dx;
	logic [DW-1:0] dy;
	logic [DW-1:0] w_e;
	logic [DW-1:0] h_e;
	pos_flags_t    flags;

	// Offsets are one bit wider than the coordinates, so the sign is exact.
	assign dx  = {pos_x[COORD_BITS-1], pos_x} - {rect_left[COORD_BITS-1], rect_left};
	assign dy  = {pos_y[COORD_BITS-1], pos_y} - {rect_top[COORD_BITS-1], rect_top};
	assign w_e = {2'b00, rect_width};
	assign h_e = {2'b00, rect_height};

	always_comb begin
		flags.in_rect = !dx[DW-1] && !dy[DW-1] && (dx < w_e) && (dy < h_e);
		flags.north   = (dy == '0);
		flags.west    = (dx == '0);
		// For an empty rectangle these match an offset of -1, which is never inside.
		flags.east    = (dx == w_e - DW'(1));
		flags.south   = (dy == h_e - DW'(1));
		flags.frame   = flags.in_rect
			&& (flags.north || flags.west || flags.east || flags.south);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dx_s1    <= dx[COORD_BITS-2:0];
			dy_s1    <= dy[COORD_BITS-2:0];
			flags_s1 <= flags;
		end
	end
endmodule

@@ design/rfpc_resolve.sv @@
// Second pipeline stage: compass direction and clockwise perimeter index,
// held in the result register. Depends on rfpc_pkg.
`timescale 1ns / 1ps

module rfpc_resolve #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         load,
	input  logic [COORD_BITS-2:0]        dx_s1,
	input  logic [COORD_BITS-2:0]        dy_s1,
	input  rfpc_pkg::pos_flags_t         flags_s1,
	input  logic [COORD_BITS-2:0]        rect_width,
	input  logic [COORD_BITS-2:0]        rect_height,
	output logic                         inside_s2,
	output logic                         frame_s2,
	output rfpc_pkg::dir_t               dir_s2,
	output logic signed [COORD_BITS+1:0] index_s2
);
	import rfpc_pkg::*;

	localparam int IDX_W = COORD_BITS + 2;

	logic [IDX_W-1:0] dx_e;
	logic [IDX_W-1:0] dy_e;
	logic [IDX_W-1:0] wm1;
	logic [IDX_W-1:0] hm1;
	logic             narrow;
	logic             short_h;
	dir_t             dir;
	logic [IDX_W-1:0] idx;

	assign dx_e    = IDX_W'(dx_s1);
	assign dy_e    = IDX_W'(dy_s1);
	assign wm1     = IDX_W'(rect_width) - IDX_W'(1);
	assign hm1     = IDX_W'(rect_height) - IDX_W'(1);
	assign narrow  = (rect_width <= (COORD_BITS-1)'(1));
	assign short_h = (rect_height <= (COORD_BITS-1)'(1));

	always_comb begin
		dir = DIR_NONE;
		if (flags_s1.frame && !narrow && !short_h) begin
			priority if (flags_s1.north && flags_s1.west) dir = DIR_NW;
			else if (flags_s1.north && flags_s1.east)     dir = DIR_NE;
			else if (flags_s1.south && flags_s1.east)     dir = DIR_SE;
			else if (flags_s1.south && flags_s1.west)     dir = DIR_SW;
			else if (flags_s1.north)                      dir = DIR_N;
			else if (flags_s1.east)                       dir = DIR_E;
			else if (flags_s1.south)                      dir = DIR_S;
			else                                          dir = DIR_W;
		end
	end

	// Perimeter runs along the top, down the right, back along the bottom and
	// up the left. Single rows and columns count straight along their length.
	always_comb begin
		idx = '1;
		if (flags_s1.frame) begin
			priority if (narrow)  idx = dy_e;
			else if (short_h)     idx = dx_e;
			else if (flags_s1.north) idx = dx_e;
			else if (flags_s1.east)  idx = wm1 + dy_e;
			else if (flags_s1.south) idx = wm1 + hm1 + (wm1 - dx_e);
			else                     idx = wm1 + wm1 + hm1 + (hm1 - dy_e);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			inside_s2 <= flags_s1.in_rect;
			frame_s2  <= flags_s1.frame;
			dir_s2    <= dir;
			index_s2  <= idx;
		end
	end
endmodule

@@ design/rect_frame_position_classifier.sv @@
// Top level of the rectangle frame position classifier: configuration
// registers, compare stage and resolve stage. Depends on rfpc_pkg, the channel
// interfaces, rfpc_cfg_regs, rfpc_compare and rfpc_resolve.
`timescale 1ns / 1ps

// The block tests each position against a configured rectangle and returns,
// for every position transaction, one result transaction telling whether the
// point is inside, whether it sits on the one-cell frame, the compass side of
// that frame and the clockwise perimeter index from the top-left corner. It
// takes one position every clock cycle unless the output stalls with stage
// one full; a result passes through two pipeline registers, one after the
// corner offset compare and one holding the result. A result that waits on
// the output does not stop a new position from entering an empty first
// stage. The configuration port is always ready and must only be written
// while no position is in flight. There is no clearing pass after reset.
module rect_frame_position_classifier #(
	parameter int COORD_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rfpc_cfg_if.sink  cfg,
	rfpc_pos_if.sink  pos,
	rfpc_res_if.source res
);
	import rfpc_pkg::*;

	logic signed [COORD_BITS-1:0] rect_left;
	logic signed [COORD_BITS-1:0] rect_top;
	logic [COORD_BITS-2:0]        rect_width;
	logic [COORD_BITS-2:0]        rect_height;

	logic [COORD_BITS-2:0] dx_s1;
	logic [COORD_BITS-2:0] dy_s1;
	pos_flags_t            flags_s1;
	dir_t                  dir_s2;

	logic v1_q;
	logic v2_q;
	logic load1;
	logic adv2;

	rfpc_cfg_regs #(.COORD_BITS(COORD_BITS)) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.rect_left   (rect_left),
		.rect_top    (rect_top),
		.rect_width  (rect_width),
		.rect_height (rect_height)
	);

	// Stage one moves forward when the result register is empty or being read.
	// The input side is ready whenever stage one is empty or moving on.
	assign adv2      = v1_q && (!v2_q || res.ready);
	assign pos.ready = !v1_q || !v2_q || res.ready;
	assign load1     = pos.valid && pos.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			if (load1) begin
				v1_q <= 1'b1;
			end else if (adv2) begin
				v1_q <= 1'b0;
			end
			if (adv2) begin
				v2_q <= 1'b1;
			end else if (res.ready) begin
				v2_q <= 1'b0;
			end
		end
	end

	rfpc_compare #(.COORD_BITS(COORD_BITS)) u_compare (
		.clk         (clk),
		.load        (load1),
		.pos_x       (pos.pos_x),
		.pos_y       (pos.pos_y),
		.rect_left   (rect_left),
		.rect_top    (rect_top),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.dx_s1       (dx_s1),
		.dy_s1       (dy_s1),
		.flags_s1    (flags_s1)
	);

	rfpc_resolve #(.COORD_BITS(COORD_BITS)) u_resolve (
		.clk         (clk),
		.load        (adv2),
		.dx_s1       (dx_s1),
		.dy_s1       (dy_s1),
		.flags_s1    (flags_s1),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.inside_s2   (res.inside_res),
		.frame_s2    (res.on_frame),
		.dir_s2      (dir_s2),
		.index_s2    (res.frame_index)
	);

	assign res.valid     = v2_q;
	assign res.direction = dir_s2;

`ifndef SYNTHESIS
	// A frame cell always lies inside the rectangle.
	a_frame_inside: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.on_frame |-> res.inside_res)
		else $error("frame result outside the rectangle");

	// Off the frame there is no direction and the index is all ones.
	a_off_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.on_frame |-> (res.direction == DIR_NONE) && (&res.frame_index))
		else $error("off-frame result carries a direction or index");

	// A position held in stage one is not dropped while the output stalls.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q && !adv2 |=> v1_q)
		else $error("stage one item lost during a stall");

	// The input is refused only when both stages hold an item that cannot move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!pos.ready |-> v1_q && v2_q && !res.ready)
		else $error("input refused with room in the pipeline");
`endif
endmodule
